[rtl/notb_pkg.sv]
// ----------------------------------------------------------------------------
// notb_pkg
// Shared types and constants of the one-shot timer bank.
// ----------------------------------------------------------------------------
package notb_pkg;

	localparam int ID_W     = 4;
	localparam int CNT_W    = 32;
	localparam int STEP_W   = 20;
	localparam int SCALE_W  = 20;
	localparam int DUR_W    = 32;
	localparam int REQ_W    = 2;
	localparam int UNIT_W   = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	// most timeout words reported by one tick
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

	// depth of the queue between front and back
	localparam int Q_DEPTH = 2;

	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [UNIT_W-1:0] unit_t;

	localparam req_t REQ_TICK  = 2'd0;
	localparam req_t REQ_START = 2'd1;
	localparam req_t REQ_STOP  = 2'd2;
	localparam req_t REQ_NONE  = 2'd3;

	localparam unit_t UNIT_S   = 2'd0;
	localparam unit_t UNIT_MS  = 2'd1;
	localparam unit_t UNIT_US  = 2'd2;
	localparam unit_t UNIT_BAD = 2'd3;

	localparam logic [SCALE_W-1:0] SCALE_S  = 20'd1000000;
	localparam logic [SCALE_W-1:0] SCALE_MS = 20'd1000;
	localparam logic [SCALE_W-1:0] SCALE_US = 20'd1;

	localparam logic [STEP_W-1:0] STEP_RESET = 20'd100;

	localparam logic KIND_TIMEOUT = 1'b0;
	localparam logic KIND_STOP    = 1'b1;

	// classified request handed from front to back
	typedef struct packed {
		req_t              req;
		logic [ID_W-1:0]   id;
		logic [CNT_W-1:0]  limit;
	} cmd_t;

endpackage

[rtl/notb_front.sv]
// ----------------------------------------------------------------------------
// notb_front
// Input stage: takes request words, drops ignored ones, scales the duration.
// ----------------------------------------------------------------------------
module notb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  notb_pkg::req_t                in_req,
	input  logic [notb_pkg::ID_W-1:0]     in_id,
	input  notb_pkg::unit_t               in_unit,
	input  logic [notb_pkg::DUR_W-1:0]    in_dur,
	output logic                          push,
	output notb_pkg::cmd_t                push_cmd,
	input  logic                          q_full
);

	logic                          valid_s1;
	notb_pkg::req_t                req_s1;
	logic [notb_pkg::ID_W-1:0]     id_s1;
	notb_pkg::unit_t               unit_s1;
	logic [notb_pkg::DUR_W-1:0]    dur_s1;

	logic                                          keep;
	logic                                          advance;
	logic [notb_pkg::SCALE_W-1:0]                  scale;
	logic [notb_pkg::DUR_W+notb_pkg::SCALE_W-1:0]  prod;
	logic [notb_pkg::CNT_W-1:0]                    limit;

	// unknown requests and starts with a bad unit leave no trace
	assign keep = (req_s1 != notb_pkg::REQ_NONE) &&
		!((req_s1 == notb_pkg::REQ_START) && (unit_s1 == notb_pkg::UNIT_BAD));
	assign push    = valid_s1 && keep && !q_full;
	assign advance = valid_s1 && (!keep || !q_full);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		unique case (unit_s1)
			notb_pkg::UNIT_S:  scale = notb_pkg::SCALE_S;
			notb_pkg::UNIT_MS: scale = notb_pkg::SCALE_MS;
			default:           scale = notb_pkg::SCALE_US;
		endcase
	end

	assign prod  = dur_s1 * scale;
	assign limit = (prod[notb_pkg::DUR_W+notb_pkg::SCALE_W-1:notb_pkg::CNT_W] != '0) ?
		'1 : prod[notb_pkg::CNT_W-1:0];

	assign push_cmd.req   = req_s1;
	assign push_cmd.id    = id_s1;
	assign push_cmd.limit = limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= in_req;
			id_s1   <= in_id;
			unit_s1 <= in_unit;
			dur_s1  <= in_dur;
		end
	end

endmodule

[rtl/notb_fifo.sv]
// ----------------------------------------------------------------------------
// notb_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module notb_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  notb_pkg::cmd_t   push_cmd,
	output logic             full,
	input  logic             pop,
	output notb_pkg::cmd_t   head,
	output logic             empty
);

	localparam int PW = (notb_pkg::Q_DEPTH > 1) ? $clog2(notb_pkg::Q_DEPTH) : 1;
	localparam int CW = $clog2(notb_pkg::Q_DEPTH + 1);

	notb_pkg::cmd_t  mem_q [notb_pkg::Q_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(notb_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(notb_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(notb_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

[rtl/notb_back.sv]
// ----------------------------------------------------------------------------
// notb_back
// Executes start, stop and tick commands on the slot store; result register.
// ----------------------------------------------------------------------------
module notb_back #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [notb_pkg::STEP_W-1:0]       cfg_wdata,
	input  logic                              q_empty,
	input  notb_pkg::cmd_t                    q_head,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_kind,
	output logic [notb_pkg::ID_W-1:0]         out_id,
	output logic [notb_pkg::CNT_W-1:0]        out_elapsed,
	output logic                              out_last
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int XW = (AW > notb_pkg::ID_W) ? AW : notb_pkg::ID_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_STOP   = 3'd1;
	localparam logic [2:0] ST_TK_RD  = 3'd2;
	localparam logic [2:0] ST_TK_EV  = 3'd3;
	localparam logic [2:0] ST_TK_END = 3'd4;

	logic [2:0]                      state_q;
	logic [notb_pkg::STEP_W-1:0]     step_q;
	logic [NUM_TIMERS-1:0]           active_q;
	logic [AW-1:0]                   scan_q;
	logic [notb_pkg::NRES_W-1:0]     nres_q;
	logic                            hold_v_q;
	logic [notb_pkg::ID_W-1:0]       hold_id_q;
	logic [notb_pkg::ID_W-1:0]       stop_id_q;
	logic                            hit_q;

	logic [notb_pkg::CNT_W-1:0]      count_mem [NUM_TIMERS];
	logic [notb_pkg::CNT_W-1:0]      limit_mem [NUM_TIMERS];
	logic [notb_pkg::CNT_W-1:0]      cnt_rd_q;
	logic [notb_pkg::CNT_W-1:0]      lim_rd_q;

	logic [XW-1:0]                   head_x;
	logic [AW-1:0]                   head_addr;
	logic                            head_ok;
	logic [AW-1:0]                   rd_addr;
	logic                            cnt_we;
	logic [notb_pkg::CNT_W-1:0]      cnt_wd;
	logic                            lim_we;

	logic                            out_free;
	logic                            emit;
	logic                            emit_kind;
	logic [notb_pkg::ID_W-1:0]       emit_id;
	logic [notb_pkg::CNT_W-1:0]      emit_elapsed;
	logic                            emit_last;

	logic                            below;
	logic [notb_pkg::CNT_W:0]        sum_w;
	logic [notb_pkg::CNT_W-1:0]      sum_sat;
	logic                            expire;
	logic                            ev_go;
	logic                            scan_end;

	assign head_x    = XW'(q_head.id);
	assign head_addr = head_x[AW-1:0];
	assign head_ok   = ({1'b0, head_x} < (XW+1)'(NUM_TIMERS));
	assign rd_addr   = (state_q == ST_IDLE) ? head_addr : scan_q;
	assign out_free  = !out_valid || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign scan_end  = (scan_q == AW'(NUM_TIMERS - 1));

	assign below   = cnt_rd_q < lim_rd_q;
	assign sum_w   = {1'b0, cnt_rd_q} + (notb_pkg::CNT_W+1)'(step_q);
	assign sum_sat = sum_w[notb_pkg::CNT_W] ? '1 : sum_w[notb_pkg::CNT_W-1:0];
	assign expire  = below && (sum_sat >= lim_rd_q) &&
		(nres_q < notb_pkg::NRES_W'(notb_pkg::MAX_RESULTS));
	// a second expiry flushes the held word, so it needs the output free
	assign ev_go   = !(expire && hold_v_q && !out_free);

	always_comb begin
		cnt_we = 1'b0;
		cnt_wd = '0;
		lim_we = 1'b0;
		if (q_pop && (q_head.req == notb_pkg::REQ_START) && head_ok) begin
			cnt_we = 1'b1;
			lim_we = 1'b1;
		end else if ((state_q == ST_TK_EV) && ev_go && below) begin
			cnt_we = 1'b1;
			cnt_wd = sum_sat;
		end
	end

	always_comb begin
		emit         = 1'b0;
		emit_kind    = notb_pkg::KIND_TIMEOUT;
		emit_id      = hold_id_q;
		emit_elapsed = '0;
		emit_last    = 1'b0;
		unique case (state_q)
			ST_STOP: begin
				emit         = out_free;
				emit_kind    = notb_pkg::KIND_STOP;
				emit_id      = stop_id_q;
				emit_elapsed = hit_q ? cnt_rd_q : '0;
				emit_last    = 1'b1;
			end
			ST_TK_EV: begin
				emit = ev_go && expire && hold_v_q;
			end
			ST_TK_END: begin
				emit      = hold_v_q && out_free;
				emit_last = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// slot store, registered read
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[(state_q == ST_IDLE) ? head_addr : scan_q] <= cnt_wd;
		end
		cnt_rd_q <= count_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (lim_we) begin
			limit_mem[head_addr] <= q_head.limit;
		end
		lim_rd_q <= limit_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= notb_pkg::STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= '0;
			scan_q   <= '0;
			nres_q   <= '0;
			hold_v_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_head.req)
							notb_pkg::REQ_START: begin
								if (head_ok) begin
									active_q[head_addr] <= 1'b1;
								end
							end
							notb_pkg::REQ_STOP: begin
								hit_q   <= head_ok && active_q[head_addr];
								scan_q  <= head_addr;
								state_q <= ST_STOP;
							end
							notb_pkg::REQ_TICK: begin
								scan_q   <= '0;
								nres_q   <= '0;
								hold_v_q <= 1'b0;
								state_q  <= ST_TK_RD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_STOP: begin
					if (out_free) begin
						if (hit_q) begin
							active_q[scan_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_TK_RD: begin
					if (active_q[scan_q]) begin
						state_q <= ST_TK_EV;
					end else if (scan_end) begin
						state_q <= ST_TK_END;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_TK_EV: begin
					if (ev_go) begin
						if (!below) begin
							active_q[scan_q] <= 1'b0;
						end
						if (expire) begin
							hold_v_q <= 1'b1;
							nres_q   <= nres_q + 1'b1;
						end
						if (scan_end) begin
							state_q <= ST_TK_END;
						end else begin
							scan_q  <= scan_q + 1'b1;
							state_q <= ST_TK_RD;
						end
					end
				end
				ST_TK_END: begin
					if (!hold_v_q || out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && q_pop && (q_head.req == notb_pkg::REQ_STOP)) begin
			stop_id_q <= q_head.id;
		end
		if ((state_q == ST_TK_EV) && ev_go && expire) begin
			hold_id_q <= notb_pkg::ID_W'(scan_q);
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind    <= emit_kind;
			out_id      <= emit_id;
			out_elapsed <= emit_elapsed;
			out_last    <= emit_last;
		end
	end

endmodule

[rtl/named_oneshot_timer_bank_core.sv]
// ----------------------------------------------------------------------------
// named_oneshot_timer_bank_core
// Bank of one-shot timers, one slot per timer id, with stop replies.
// ----------------------------------------------------------------------------
// Requests enter on the slave stream and are queued two deep ahead of the
// slot engine, so the input keeps flowing while the engine or the result
// stream stalls, as long as the queue has room. The engine handles one
// request at a time against the slot store (one read and one write port);
// a tick visits every slot in id order through the store's read port.
// Waiting on m_axis_tready can hold a stop or a tick. A tick reports up to
// 16 timeouts, each word one slot id, with tlast on the final one; a tick
// with no expiry sends nothing. Every stop returns exactly one word. There
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module named_oneshot_timer_bank_core #(
	parameter int NUM_TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,       // tick_step_us
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,    // timer_id[3:0], time_unit[5:4], duration[37:6]
	input  logic [1:0]  s_axis_tuser,    // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,    // result_id[3:0], elapsed_us[35:4]
	output logic [0:0]  m_axis_tuser,    // result_kind[0]
	output logic        m_axis_tlast
);

	logic                            push;
	notb_pkg::cmd_t                  push_cmd;
	logic                            q_full;
	logic                            q_pop;
	notb_pkg::cmd_t                  q_head;
	logic                            q_empty;
	logic                            out_kind;
	logic [notb_pkg::ID_W-1:0]       out_id;
	logic [notb_pkg::CNT_W-1:0]      out_elapsed;

	notb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (s_axis_tuser),
		.in_id    (s_axis_tdata[3:0]),
		.in_unit  (s_axis_tdata[5:4]),
		.in_dur   (s_axis_tdata[37:6]),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	notb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	notb_back #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (out_kind),
		.out_id      (out_id),
		.out_elapsed (out_elapsed),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, out_elapsed, out_id};
	assign m_axis_tuser = out_kind;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the one-shot timer bank core.
// ----------------------------------------------------------------------------
// A queue of requests feeds a stream driver. A monitor on the rising edge
// runs every accepted request through a local copy of the slot bank and
// checks each result word against what the bank should produce. The run
// walks through several tick steps and three stall patterns. It includes
// a short tick run at the largest step against saturated limits.
// ----------------------------------------------------------------------------
module tb;

	localparam int NUM_TIMERS    = 16;
	localparam int SETTLE_CYCLES = 200;
	localparam int QUIET_LIMIT   = 10000;

	typedef struct packed {
		notb_pkg::req_t                  req;
		logic [notb_pkg::ID_W-1:0]       id;
		notb_pkg::unit_t                 unit;
		logic [notb_pkg::DUR_W-1:0]      dur;
	} timer_req_t;

	typedef struct packed {
		logic                            kind;
		logic [notb_pkg::ID_W-1:0]       id;
		logic [notb_pkg::CNT_W-1:0]      elapsed;
		logic                            last;
	} timer_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [19:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;    // timer_id[3:0], time_unit[5:4], duration[37:6]
	logic [1:0]  s_axis_tuser;    // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;    // result_id[3:0], elapsed_us[35:4]
	logic [0:0]  m_axis_tuser;    // result_kind[0]
	logic        m_axis_tlast;

	timer_req_t  cur_req = '0;
	timer_req_t  pending[$];
	timer_word_t expected_words[$];
	timer_word_t want;
	logic        req_taken = 1'b0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	// local copy of the bank
	logic                         slot_on[NUM_TIMERS];
	logic [notb_pkg::CNT_W-1:0]   slot_cnt[NUM_TIMERS];
	logic [notb_pkg::CNT_W-1:0]   slot_lim[NUM_TIMERS];
	logic [notb_pkg::STEP_W-1:0]  step_us;

	assign s_axis_tdata = {2'b00, cur_req.dur, cur_req.unit, cur_req.id};
	assign s_axis_tuser = cur_req.req;

	named_oneshot_timer_bank_core #(
		.NUM_TIMERS(NUM_TIMERS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Applies one request to the local bank and queues the words it causes.
	task automatic timer_bank_step(input timer_req_t r);
		timer_word_t w;
		timer_word_t fired[$];
		logic [32:0] sum;
		logic [63:0] lim;
		case (r.req)
		notb_pkg::REQ_TICK: begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (slot_on[i]) begin
					if (slot_cnt[i] < slot_lim[i]) begin
						sum = {1'b0, slot_cnt[i]} + 33'(step_us);
						slot_cnt[i] = sum[32] ? '1 : sum[31:0];
						if (slot_cnt[i] >= slot_lim[i] &&
								fired.size() < notb_pkg::MAX_RESULTS) begin
							w.kind = notb_pkg::KIND_TIMEOUT;
							w.id = notb_pkg::ID_W'(i);
							w.elapsed = '0;
							w.last = 1'b0;
							fired.push_back(w);
						end
					end else begin
						// already at its limit: freed quietly
						slot_on[i] = 1'b0;
					end
				end
			end
			if (fired.size() != 0)
				fired[fired.size() - 1].last = 1'b1;
			foreach (fired[k])
				expected_words.push_back(fired[k]);
		end
		notb_pkg::REQ_START: begin
			if (r.unit != notb_pkg::UNIT_BAD && int'(r.id) < NUM_TIMERS) begin
				case (r.unit)
				notb_pkg::UNIT_S:  lim = 64'(r.dur) * 64'(notb_pkg::SCALE_S);
				notb_pkg::UNIT_MS: lim = 64'(r.dur) * 64'(notb_pkg::SCALE_MS);
				default:           lim = 64'(r.dur);
				endcase
				slot_lim[r.id] = (lim > 64'hFFFF_FFFF) ? '1 : lim[31:0];
				slot_cnt[r.id] = '0;
				slot_on[r.id] = 1'b1;
			end
		end
		notb_pkg::REQ_STOP: begin
			w.kind = notb_pkg::KIND_STOP;
			w.id = r.id;
			w.elapsed = '0;
			w.last = 1'b1;
			if (int'(r.id) < NUM_TIMERS && slot_on[r.id]) begin
				w.elapsed = slot_cnt[r.id];
				slot_on[r.id] = 1'b0;
			end
			expected_words.push_back(w);
		end
		default: ;
		endcase
	endtask

	function automatic void push_req(input notb_pkg::req_t req, input int id,
			input notb_pkg::unit_t unit, input logic [31:0] dur);
		timer_req_t r;
		r.req = req;
		r.id = notb_pkg::ID_W'(id);
		r.unit = unit;
		r.dur = dur;
		pending.push_back(r);
	endfunction

	// Mostly short timers so that ticks expire them; some full-range durations.
	function automatic timer_req_t random_request();
		timer_req_t r;
		int unsigned pick;
		int unsigned span;
		r.req = notb_pkg::REQ_TICK;
		r.id = notb_pkg::ID_W'($urandom());
		r.unit = notb_pkg::unit_t'($urandom_range(0, 2));
		r.dur = $urandom();
		pick = $urandom_range(99);
		span = 8 * ((step_us == 0) ? 1 : int'(step_us));
		if (pick < 40) begin
			r.req = notb_pkg::REQ_TICK;
		end else if (pick < 72) begin
			r.req = notb_pkg::REQ_START;
			if ($urandom_range(19) == 0) begin
				r.unit = notb_pkg::UNIT_BAD;
			end else if ($urandom_range(9) != 0) begin
				case (r.unit)
				notb_pkg::UNIT_S:  r.dur = $urandom_range(0, span / 1000000 + 1);
				notb_pkg::UNIT_MS: r.dur = $urandom_range(0, span / 1000 + 1);
				default:           r.dur = $urandom_range(0, span + span / 8);
				endcase
			end
		end else if (pick < 94) begin
			r.req = notb_pkg::REQ_STOP;
		end else begin
			r.req = notb_pkg::REQ_NONE;
		end
		return r;
	endfunction

	task automatic add_random(input int n);
		repeat (n) pending.push_back(random_request());
	endtask

	task automatic write_step(input logic [notb_pkg::STEP_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		step_us = value;
		@(posedge clk);
	endtask

	// Waits until every request is in and every word is out, then lets the
	// engine finish any request that causes no word.
	task automatic wait_drained();
		while (pending.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stream driver
	always @(negedge clk) begin
		timer_req_t next_req;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || req_taken) begin
			if (pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				next_req = pending.pop_front();
				cur_req <= next_req;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// monitor: prediction on accepted requests, check on accepted words
	always @(posedge clk) begin
		req_taken <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				timer_bank_step(cur_req);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word, id %0d kind %0b",
						m_axis_tdata[3:0], m_axis_tuser[0]));
				end else begin
					want = expected_words.pop_front();
					if (m_axis_tuser[0] !== want.kind)
						report_mismatch($sformatf("id %0d: kind %b, want %b",
							want.id, m_axis_tuser[0], want.kind));
					if (m_axis_tdata[3:0] !== want.id)
						report_mismatch($sformatf("id %0d, want %0d",
							m_axis_tdata[3:0], want.id));
					if (m_axis_tdata[35:4] !== want.elapsed)
						report_mismatch($sformatf("id %0d: elapsed %0d, want %0d",
							want.id, m_axis_tdata[35:4], want.elapsed));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("id %0d: last %b, want %b",
							want.id, m_axis_tlast, want.last));
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** named_oneshot_timer_bank_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		step_us = notb_pkg::STEP_RESET;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			slot_on[i] = 1'b0;
			slot_cnt[i] = '0;
			slot_lim[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// sender idles a little, receiver a lot
		src_idle_pct = 19;
		sink_idle_pct = 73;
		push_req(notb_pkg::REQ_START, 0, notb_pkg::UNIT_S, 32'd0);            // zero limit
		push_req(notb_pkg::REQ_START, 1, notb_pkg::UNIT_US, 32'd250);
		push_req(notb_pkg::REQ_START, 2, notb_pkg::UNIT_MS, 32'd1);
		push_req(notb_pkg::REQ_START, 15, notb_pkg::UNIT_S, 32'hFFFF_FFFF);   // saturates
		push_req(notb_pkg::REQ_START, 3, notb_pkg::UNIT_BAD, 32'd5);          // ignored
		push_req(notb_pkg::REQ_NONE, 7, notb_pkg::UNIT_MS, 32'hA5A5_A5A5);    // ignored
		push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);             // frees slot 0
		push_req(notb_pkg::REQ_STOP, 3, notb_pkg::UNIT_S, 32'd0);             // never started
		push_req(notb_pkg::REQ_TICK, 9, notb_pkg::UNIT_US, 32'h5A5A_5A5A);
		push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);             // slot 1 expires
		push_req(notb_pkg::REQ_STOP, 15, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_STOP, 0, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_START, 4, notb_pkg::UNIT_US, 32'd100);
		push_req(notb_pkg::REQ_START, 5, notb_pkg::UNIT_US, 32'hFFFF_FFFF);
		push_req(notb_pkg::REQ_START, 1, notb_pkg::UNIT_MS, 32'hFFFF_FFFF);
		push_req(notb_pkg::REQ_START, 2, notb_pkg::UNIT_US, 32'd50);          // restart
		push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);             // two expiries
		push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_STOP, 2, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_STOP, 1, notb_pkg::UNIT_S, 32'hFFFF_FFFF);
		push_req(notb_pkg::REQ_TICK, 15, notb_pkg::UNIT_BAD, 32'd0);
		push_req(notb_pkg::REQ_STOP, 5, notb_pkg::UNIT_S, 32'd0);
		add_random(25);
		wait_drained();

		// counts stand still
		write_step('0);
		push_req(notb_pkg::REQ_START, 6, notb_pkg::UNIT_US, 32'd1);
		push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_STOP, 6, notb_pkg::UNIT_S, 32'd0);
		add_random(12);
		wait_drained();

		// receiver idles a little, sender a lot
		src_idle_pct = 73;
		sink_idle_pct = 19;
		write_step(20'd1);
		add_random(15);
		wait_drained();
		write_step(20'd1000000);
		add_random(15);
		wait_drained();

		// no idling: largest step against saturated limits
		src_idle_pct = 0;
		sink_idle_pct = 0;
		write_step(20'hFFFFF);
		push_req(notb_pkg::REQ_START, 9, notb_pkg::UNIT_S, 32'd4295);
		push_req(notb_pkg::REQ_START, 10, notb_pkg::UNIT_US, 32'hFFFF_FFFF);
		repeat (4) push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_STOP, 9, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);
		push_req(notb_pkg::REQ_STOP, 10, notb_pkg::UNIT_S, 32'd0);
		wait_drained();

		// every slot expires on the same tick
		write_step(notb_pkg::STEP_W'($urandom_range(1, 1000000)));
		for (int i = 0; i < NUM_TIMERS; i++)
			push_req(notb_pkg::REQ_START, i, notb_pkg::UNIT_US, 32'(step_us));
		push_req(notb_pkg::REQ_TICK, 0, notb_pkg::UNIT_S, 32'd0);
		add_random(12);
		wait_drained();

		if (mismatches == 0)
			$display("** named_oneshot_timer_bank_core: PASSED **");
		else
			$display("** named_oneshot_timer_bank_core: FAILED **");
		$finish;
	end

endmodule

[named_oneshot_timer_bank_core.f]
rtl/notb_pkg.sv
rtl/notb_front.sv
rtl/notb_fifo.sv
rtl/notb_back.sv
rtl/named_oneshot_timer_bank_core.sv
test/tb.sv
